@@ src/dsf_pkg.sv @@
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types, widths, register codes and helpers for the damped spring
// force pipeline.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned DiffW  = FieldW + 1;
  localparam int unsigned RadW   = 2 * DiffW;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned QW     = 17;
  localparam int unsigned NumW   = DiffW + 16;
  localparam int unsigned SW     = RootW + 1;
  localparam int unsigned GW     = 32;
  localparam int unsigned MagW   = GW + SW - 16;
  localparam int unsigned FbW    = MagW + 1;
  localparam int unsigned DpW    = GW + 1;
  localparam int unsigned SumW   = FbW + 1;

  localparam logic [CfgW-1:0] SpringConstantRst = CfgW'(65536);
  localparam logic [CfgW-1:0] RestLengthRst     = CfgW'(65536);

  typedef enum logic [0:0] {
    CFG_SPRING_CONSTANT = 1'b0,
    CFG_REST_LENGTH     = 1'b1
  } cfg_idx_e;

  // Lane order: dx, dy, rx, ry.
  typedef struct packed {
    logic [3:0]                  neg;
    logic [3:0][DiffW-1:0]       mag;
    logic [CfgW-1:0]             damp;
  } sq_pay_t;

  typedef struct packed {
    logic signed [SW-1:0] s;
    logic                 zero;
    logic                 vnz;
    logic [3:0]           neg;
    logic [CfgW-1:0]      damp;
  } div_pay_t;

  function automatic logic signed [FieldW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [FieldW-1:0] r;
    if (&v[SumW-1:FieldW-1] || ~|v[SumW-1:FieldW-1]) begin
      r = v[FieldW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(FieldW-1){1'b0}}};
    end else begin
      r = {1'b0, {(FieldW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/dsf_front.sv @@
// ----------------------------------------------------------------------------
// dsf_front
// Differences, magnitudes, squares and sums of squares, four stages.
// ----------------------------------------------------------------------------
module dsf_front import dsf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [FieldW-1:0]    pos_a_x_i,
  input  logic signed [FieldW-1:0]    pos_a_y_i,
  input  logic signed [FieldW-1:0]    pos_b_x_i,
  input  logic signed [FieldW-1:0]    pos_b_y_i,
  input  logic signed [FieldW-1:0]    vel_a_x_i,
  input  logic signed [FieldW-1:0]    vel_a_y_i,
  input  logic signed [FieldW-1:0]    vel_b_x_i,
  input  logic signed [FieldW-1:0]    vel_b_y_i,
  input  logic        [CfgW-1:0]      damping_a_i,
  output logic                        valid_o,
  output logic [1:0][RadW-1:0]        rad_o,
  output sq_pay_t                     pay_o
);

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic [3:0][DiffW-1:0]   diff_d, diff_q;
  logic [CfgW-1:0]         c1_q;
  sq_pay_t                 abs_d, abs_q, sq_pay_q, rad_pay_q;
  logic [3:0][RadW-1:0]    sq_d, sq_q;
  logic [1:0][RadW-1:0]    rad_d, rad_q;

  always_comb begin
    diff_d[0] = {pos_b_x_i[FieldW-1], pos_b_x_i} - {pos_a_x_i[FieldW-1], pos_a_x_i};
    diff_d[1] = {pos_b_y_i[FieldW-1], pos_b_y_i} - {pos_a_y_i[FieldW-1], pos_a_y_i};
    diff_d[2] = {vel_a_x_i[FieldW-1], vel_a_x_i} - {vel_b_x_i[FieldW-1], vel_b_x_i};
    diff_d[3] = {vel_a_y_i[FieldW-1], vel_a_y_i} - {vel_b_y_i[FieldW-1], vel_b_y_i};
  end

  always_comb begin
    abs_d.damp = c1_q;
    for (int l = 0; l < 4; l++) begin
      abs_d.neg[l] = diff_q[l][DiffW-1];
      abs_d.mag[l] = diff_q[l][DiffW-1] ? DiffW'(-diff_q[l]) : diff_q[l];
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sq_d[l] = {{DiffW{1'b0}}, abs_q.mag[l]} * {{DiffW{1'b0}}, abs_q.mag[l]};
    end
    rad_d[0] = sq_q[0] + sq_q[1];
    rad_d[1] = sq_q[2] + sq_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q    <= diff_d;
      c1_q      <= damping_a_i;
      abs_q     <= abs_d;
      sq_q      <= sq_d;
      sq_pay_q  <= abs_q;
      rad_q     <= rad_d;
      rad_pay_q <= sq_pay_q;
    end
  end

  assign valid_o = v4_q;
  assign rad_o   = rad_q;
  assign pay_o   = rad_pay_q;

endmodule

@@ src/dsf_isqrt.sv @@
// ----------------------------------------------------------------------------
// dsf_isqrt
// Pipelined integer square root, one result bit per stage, several lanes.
// ----------------------------------------------------------------------------
module dsf_isqrt import dsf_pkg::*; #(
  parameter int unsigned Lanes    = 2,
  parameter int unsigned PayloadW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [Lanes-1:0][RadW-1:0]       rad_i,
  input  logic [PayloadW-1:0]              pay_i,
  output logic                             valid_o,
  output logic [Lanes-1:0][RootW-1:0]      root_o,
  output logic [PayloadW-1:0]              pay_o
);

  localparam int unsigned RemW = RootW + 3;

  logic                             vld_q  [RootW+1];
  logic [Lanes-1:0][RadW-1:0]       val_q  [RootW+1];
  logic [Lanes-1:0][RemW-1:0]       rem_q  [RootW+1];
  logic [Lanes-1:0][RootW-1:0]      root_q [RootW+1];
  logic [PayloadW-1:0]              pay_q  [RootW+1];

  assign vld_q[0]  = valid_i;
  assign val_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign pay_q[0]  = pay_i;

  for (genvar j = 0; j < RootW; j++) begin : g_step
    logic [Lanes-1:0][RadW-1:0]  val_d;
    logic [Lanes-1:0][RemW-1:0]  rem_d;
    logic [Lanes-1:0][RootW-1:0] root_d;

    always_comb begin
      logic [RemW-1:0] rem_sh;
      logic [RemW-1:0] trial;
      for (int l = 0; l < Lanes; l++) begin
        rem_sh   = {rem_q[j][l][RemW-3:0], val_q[j][l][RadW-1:RadW-2]};
        trial    = RemW'({root_q[j][l], 2'b01});
        val_d[l] = {val_q[j][l][RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d[l]  = rem_sh - trial;
          root_d[l] = {root_q[j][l][RootW-2:0], 1'b1};
        end else begin
          rem_d[l]  = rem_sh;
          root_d[l] = {root_q[j][l][RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[j+1]  <= val_d;
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
        pay_q[j+1]  <= pay_q[j];
      end
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign pay_o   = pay_q[RootW];

endmodule

@@ src/dsf_div.sv @@
// ----------------------------------------------------------------------------
// dsf_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// ----------------------------------------------------------------------------
module dsf_div import dsf_pkg::*; #(
  parameter int unsigned Lanes    = 4,
  parameter int unsigned PayloadW = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [Lanes-1:0][NumW-1:0]     num_i,
  input  logic [Lanes-1:0][RootW-1:0]    den_i,
  input  logic [PayloadW-1:0]            pay_i,
  output logic                           valid_o,
  output logic [Lanes-1:0][QW-1:0]       quot_o,
  output logic [PayloadW-1:0]            pay_o
);

  logic                         vld_q  [QW+1];
  logic [Lanes-1:0][RootW-1:0]  rem_q  [QW+1];
  logic [Lanes-1:0][RootW-1:0]  den_q  [QW+1];
  logic [Lanes-1:0][QW-1:0]     low_q  [QW+1];
  logic [Lanes-1:0][QW-1:0]     quot_q [QW+1];
  logic [PayloadW-1:0]          pay_q  [QW+1];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rem_q[0][l] = RootW'(num_i[l][NumW-1:QW]);
      low_q[0][l] = num_i[l][QW-1:0];
    end
  end

  assign vld_q[0]  = valid_i;
  assign den_q[0]  = den_i;
  assign quot_q[0] = '0;
  assign pay_q[0]  = pay_i;

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [Lanes-1:0][RootW-1:0] rem_d;
    logic [Lanes-1:0][QW-1:0]    low_d;
    logic [Lanes-1:0][QW-1:0]    quot_d;

    always_comb begin
      logic [RootW:0] rem_sh;
      logic [RootW:0] den_x;
      for (int l = 0; l < Lanes; l++) begin
        rem_sh   = {rem_q[j][l], low_q[j][l][QW-1]};
        den_x    = {1'b0, den_q[j][l]};
        low_d[l] = {low_q[j][l][QW-2:0], 1'b0};
        if (rem_sh >= den_x) begin
          rem_d[l]  = RootW'(rem_sh - den_x);
          quot_d[l] = {quot_q[j][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l]  = RootW'(rem_sh);
          quot_d[l] = {quot_q[j][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        den_q[j+1]  <= den_q[j];
        low_q[j+1]  <= low_d;
        quot_q[j+1] <= quot_d;
        pay_q[j+1]  <= pay_q[j];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quot_q[QW];
  assign pay_o   = pay_q[QW];

endmodule

@@ src/dsf_back.sv @@
// ----------------------------------------------------------------------------
// dsf_back
// Scaling by stiffness, stretch and damping, signs, sums and saturation.
// ----------------------------------------------------------------------------
module dsf_back import dsf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [3:0][QW-1:0]        quot_i,
  input  div_pay_t                  pay_i,
  input  logic [CfgW-1:0]           spring_constant_i,
  output logic                      valid_o,
  output logic signed [FieldW-1:0]  force_a_x_o,
  output logic signed [FieldW-1:0]  force_a_y_o,
  output logic signed [FieldW-1:0]  force_b_x_o,
  output logic signed [FieldW-1:0]  force_b_y_o,
  output logic                      zero_length_o
);

  localparam int unsigned ProdW = QW + CfgW;

  logic                         ve_q, vf_q, vg_q;
  logic [1:0][GW-1:0]           g_d, g_q, dm_d, dm_q;
  logic [SW-1:0]                sabs_d, sabs_q;
  logic                         sneg_q, ze_q, zf_q, zg_q;
  logic [3:0]                   neg_q;
  logic [1:0][FbW-1:0]          fb_d, fb_q;
  logic [1:0][DpW-1:0]          dp_d, dp_q;
  logic signed [FieldW-1:0]     fax_q, fay_q, fbx_q, fby_q;
  logic signed [SumW-1:0]       sa_x, sa_y, sb_x, sb_y;

  always_comb begin
    logic [ProdW-1:0] gp;
    logic [ProdW-1:0] dp;
    for (int l = 0; l < 2; l++) begin
      gp = {{CfgW{1'b0}}, quot_i[l]} * {{QW{1'b0}}, spring_constant_i};
      dp = {{CfgW{1'b0}}, quot_i[l+2]} * {{QW{1'b0}}, pay_i.damp};
      g_d[l]  = pay_i.zero ? '0 : gp[ProdW-1:16];
      dm_d[l] = pay_i.vnz ? dp[ProdW-1:16] : '0;
    end
    sabs_d = pay_i.s[SW-1] ? SW'(-pay_i.s) : SW'(pay_i.s);
  end

  always_comb begin
    logic [GW+SW-1:0] mp;
    logic [MagW-1:0]  mag;
    for (int l = 0; l < 2; l++) begin
      mp  = {{SW{1'b0}}, g_q[l]} * {{GW{1'b0}}, sabs_q};
      mag = mp[GW+SW-1:16];
      fb_d[l] = (neg_q[l] == sneg_q) ? FbW'(-{1'b0, mag}) : {1'b0, mag};
      dp_d[l] = neg_q[l+2] ? {1'b0, dm_q[l]} : DpW'(-{1'b0, dm_q[l]});
    end
  end

  always_comb begin
    sb_x = {fb_q[0][FbW-1], fb_q[0]};
    sb_y = {fb_q[1][FbW-1], fb_q[1]};
    sa_x = -sb_x + {{(SumW-DpW){dp_q[0][DpW-1]}}, dp_q[0]};
    sa_y = -sb_y + {{(SumW-DpW){dp_q[1][DpW-1]}}, dp_q[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= valid_i;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q    <= g_d;
      dm_q   <= dm_d;
      sabs_q <= sabs_d;
      sneg_q <= pay_i.s[SW-1];
      neg_q  <= pay_i.neg;
      ze_q   <= pay_i.zero;
      fb_q   <= fb_d;
      dp_q   <= dp_d;
      zf_q   <= ze_q;
      fax_q  <= sat32(sa_x);
      fay_q  <= sat32(sa_y);
      fbx_q  <= sat32(sb_x);
      fby_q  <= sat32(sb_y);
      zg_q   <= zf_q;
    end
  end

  assign valid_o       = vg_q;
  assign force_a_x_o   = fax_q;
  assign force_a_y_o   = fay_q;
  assign force_b_x_o   = fbx_q;
  assign force_b_y_o   = fby_q;
  assign zero_length_o = zg_q;

endmodule

@@ src/damped_spring_force_2d.sv @@
// ----------------------------------------------------------------------------
// damped_spring_force_2d
// Hooke spring force with fixed-magnitude damping between two particles.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_ready   positions, velocities, damping
//   out       output     out_valid / out_ready forces, zero length flag
//   cfg       input      cfg_we                cfg_idx, cfg_data
//
// One item enters per cycle while the output is not stalled; each passes through
// the 33 root stages and 17 quotient stages plus seven arithmetic stages.
// Reset clears the valid bits and sets both registers to 1.0.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module damped_spring_force_2d import dsf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [FieldW-1:0]  pos_a_x_i,
  input  logic signed [FieldW-1:0]  pos_a_y_i,
  input  logic signed [FieldW-1:0]  pos_b_x_i,
  input  logic signed [FieldW-1:0]  pos_b_y_i,
  input  logic signed [FieldW-1:0]  vel_a_x_i,
  input  logic signed [FieldW-1:0]  vel_a_y_i,
  input  logic signed [FieldW-1:0]  vel_b_x_i,
  input  logic signed [FieldW-1:0]  vel_b_y_i,
  input  logic        [CfgW-1:0]    damping_a_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [FieldW-1:0]  force_a_x_o,
  output logic signed [FieldW-1:0]  force_a_y_o,
  output logic signed [FieldW-1:0]  force_b_x_o,
  output logic signed [FieldW-1:0]  force_b_y_o,
  output logic                      zero_length_o
);

  logic                      en;
  logic [CfgW-1:0]           k_q, len_q;
  logic                      fr_valid, sq_valid, dv_valid;
  logic [1:0][RadW-1:0]      rad;
  sq_pay_t                   sq_pay, rt_pay;
  logic [1:0][RootW-1:0]     root;
  logic [3:0][NumW-1:0]      num;
  logic [3:0][RootW-1:0]     den;
  div_pay_t                  dv_in, dv_out;
  logic [3:0][QW-1:0]        quot;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= SpringConstantRst;
      len_q <= RestLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPRING_CONSTANT: k_q   <= cfg_data_i;
        CFG_REST_LENGTH:     len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsf_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .pos_a_x_i, .pos_a_y_i, .pos_b_x_i, .pos_b_y_i,
    .vel_a_x_i, .vel_a_y_i, .vel_b_x_i, .vel_b_y_i, .damping_a_i,
    .valid_o(fr_valid), .rad_o(rad), .pay_o(sq_pay)
  );

  dsf_isqrt #(.Lanes(2), .PayloadW($bits(sq_pay_t))) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .rad_i(rad), .pay_i(sq_pay),
    .valid_o(sq_valid), .root_o(root), .pay_o(rt_pay)
  );

  always_comb begin
    dv_in.s    = $signed({1'b0, root[0]}) - $signed(SW'(len_q));
    dv_in.zero = (root[0] == '0);
    dv_in.vnz  = (root[1] != '0);
    dv_in.neg  = rt_pay.neg;
    dv_in.damp = rt_pay.damp;
    for (int l = 0; l < 4; l++) begin
      num[l] = {rt_pay.mag[l], 16'b0};
    end
    den[0] = root[0];
    den[1] = root[0];
    den[2] = root[1];
    den[3] = root[1];
  end

  dsf_div #(.Lanes(4), .PayloadW($bits(div_pay_t))) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .num_i(num), .den_i(den),
    .pay_i(dv_in), .valid_o(dv_valid), .quot_o(quot), .pay_o(dv_out)
  );

  dsf_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_valid), .quot_i(quot), .pay_i(dv_out),
    .spring_constant_i(k_q), .valid_o(out_valid_o),
    .force_a_x_o, .force_a_y_o, .force_b_x_o, .force_b_y_o, .zero_length_o
  );

endmodule
